>>> design/cft_pkg.sv
// ----------------------------------------------------------------------------
// cft_pkg
// Shared types and constants for the CSV field tokenizer.
// ----------------------------------------------------------------------------
package cft_pkg;

   localparam int unsigned MAX_FIELDS_DEFAULT = 255;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_END    = 8'h00;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

   typedef enum logic [5:0] {
      MODE_START    = 6'b000001,
      MODE_BARE     = 6'b000010,
      MODE_QUOTED   = 6'b000100,
      MODE_Q_BSLASH = 6'b001000,
      MODE_Q_QUOTE  = 6'b010000,
      MODE_SKIP     = 6'b100000
   } mode_type;

   typedef struct packed {
      logic [1:0] content_count;
      logic [7:0] content_first;
      logic [7:0] content_second;
      logic       field_end;
      logic       row_end;
      logic [1:0] row_status;
      logic [8:0] error_field;
      logic [7:0] fields_so_far;
   } result_type;

endpackage

>>> design/cft_parse_core.sv
// ----------------------------------------------------------------------------
// cft_parse_core
// Parser state (mode, field count, row started) and the one-byte step logic.
// ----------------------------------------------------------------------------
module cft_parse_core #(
   parameter int unsigned MAX_FIELDS = cft_pkg::MAX_FIELDS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         data_byte,
   output cft_pkg::result_type result
);

   localparam int unsigned LIMIT   = (MAX_FIELDS < 255) ? MAX_FIELDS : 255;
   localparam logic [7:0]  LIMIT_B = 8'(LIMIT);
   localparam logic [8:0]  LIMIT_ERR = 9'(LIMIT + 1);

   cft_pkg::mode_type mode_ff, mode_in;
   logic [7:0]        total_ff, total_in;
   logic              started_ff, started_in;

   logic [7:0] total_inc;
   logic [7:0] total_after;
   logic [8:0] err_acc;
   logic       acc, fin, is_term;
   logic [1:0] st;
   logic [8:0] err;
   logic [1:0] cnt;
   logic [7:0] c0, c1;
   cft_pkg::mode_type nmode;

   assign total_inc = (total_ff == 8'hFF) ? total_ff : total_ff + 8'd1;
   assign err_acc   = {1'b0, total_inc} + 9'd1;
   assign is_term   = (data_byte == cft_pkg::CH_NL) || (data_byte == cft_pkg::CH_END);

   always_comb begin
      acc   = 1'b0;
      fin   = 1'b0;
      st    = cft_pkg::STATUS_OK;
      err   = '0;
      cnt   = 2'd0;
      c0    = '0;
      c1    = '0;
      nmode = mode_ff;
      unique case (mode_ff)
         cft_pkg::MODE_BARE: begin
            if (data_byte == cft_pkg::CH_COMMA) begin
               acc   = 1'b1;
               nmode = cft_pkg::MODE_START;
            end else if (data_byte == cft_pkg::CH_NL) begin
               acc = 1'b1;
               fin = 1'b1;
            end else if (data_byte == cft_pkg::CH_END) begin
               acc = 1'b1;
               fin = 1'b1;
               st  = cft_pkg::STATUS_MALFORMED;
               err = err_acc;
            end else begin
               cnt = 2'd1;
               c0  = data_byte;
            end
         end
         cft_pkg::MODE_QUOTED: begin
            if (is_term) begin
               acc = 1'b1;
               fin = 1'b1;
               st  = cft_pkg::STATUS_MALFORMED;
               err = err_acc;
            end else if (data_byte == cft_pkg::CH_BSLASH) begin
               nmode = cft_pkg::MODE_Q_BSLASH;
            end else if (data_byte == cft_pkg::CH_QUOTE) begin
               nmode = cft_pkg::MODE_Q_QUOTE;
            end else begin
               cnt = 2'd1;
               c0  = data_byte;
            end
         end
         cft_pkg::MODE_Q_BSLASH: begin
            cnt = 2'd1;
            c0  = cft_pkg::CH_BSLASH;
            if (data_byte == cft_pkg::CH_QUOTE) begin
               cnt   = 2'd2;
               c1    = cft_pkg::CH_QUOTE;
               nmode = cft_pkg::MODE_QUOTED;
            end else if (is_term) begin
               acc = 1'b1;
               fin = 1'b1;
               st  = cft_pkg::STATUS_MALFORMED;
               err = err_acc;
            end else if (data_byte == cft_pkg::CH_BSLASH) begin
               nmode = cft_pkg::MODE_Q_BSLASH;
            end else begin
               cnt   = 2'd2;
               c1    = data_byte;
               nmode = cft_pkg::MODE_QUOTED;
            end
         end
         cft_pkg::MODE_Q_QUOTE: begin
            if (data_byte == cft_pkg::CH_QUOTE) begin
               cnt   = 2'd2;
               c0    = cft_pkg::CH_QUOTE;
               c1    = cft_pkg::CH_QUOTE;
               nmode = cft_pkg::MODE_QUOTED;
            end else if (data_byte == cft_pkg::CH_COMMA) begin
               acc   = 1'b1;
               nmode = cft_pkg::MODE_START;
            end else if (data_byte == cft_pkg::CH_NL) begin
               acc = 1'b1;
               fin = 1'b1;
            end else begin
               acc = 1'b1;
               fin = 1'b1;
               st  = cft_pkg::STATUS_MALFORMED;
               err = err_acc;
            end
         end
         default: begin
            if (data_byte == cft_pkg::CH_END) begin
               fin = 1'b1;
               if (!started_ff) begin
                  st  = cft_pkg::STATUS_MALFORMED;
                  err = 9'd1;
               end
            end else if (total_ff >= LIMIT_B) begin
               fin = 1'b1;
               st  = cft_pkg::STATUS_OVERFLOW;
               err = LIMIT_ERR;
            end else if (data_byte == cft_pkg::CH_QUOTE) begin
               nmode = cft_pkg::MODE_QUOTED;
            end else if (data_byte == cft_pkg::CH_COMMA) begin
               acc   = 1'b1;
               nmode = cft_pkg::MODE_START;
            end else if (data_byte == cft_pkg::CH_NL) begin
               acc = 1'b1;
               fin = 1'b1;
            end else begin
               cnt   = 2'd1;
               c0    = data_byte;
               nmode = cft_pkg::MODE_BARE;
            end
         end
      endcase
   end

   assign total_after = acc ? total_inc : total_ff;

   always_comb begin
      result     = '0;
      mode_in    = mode_ff;
      total_in   = total_ff;
      started_in = started_ff;
      if (mode_ff == cft_pkg::MODE_SKIP) begin
         if (is_term) begin
            mode_in    = cft_pkg::MODE_START;
            total_in   = '0;
            started_in = 1'b0;
         end
      end else begin
         result.content_count  = cnt;
         result.content_first  = c0;
         result.content_second = c1;
         result.field_end      = acc;
         result.fields_so_far  = total_after;
         if (fin) begin
            result.row_end     = 1'b1;
            result.row_status  = st;
            result.error_field = err;
            total_in           = '0;
            started_in         = 1'b0;
            mode_in            = (st != cft_pkg::STATUS_OK && !is_term) ?
                                 cft_pkg::MODE_SKIP : cft_pkg::MODE_START;
         end else begin
            total_in   = total_after;
            started_in = 1'b1;
            mode_in    = nmode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= cft_pkg::MODE_START;
         total_ff   <= '0;
         started_ff <= 1'b0;
      end else if (step) begin
         mode_ff    <= mode_in;
         total_ff   <= total_in;
         started_ff <= started_in;
      end
   end

   a_count_le_limit: assert property (@(posedge clock) disable iff (reset)
      total_ff <= LIMIT_B)
      else $error("field count above limit");

   a_skip_quiet: assert property (@(posedge clock) disable iff (reset)
      (step && mode_ff == cft_pkg::MODE_SKIP) |-> (result == '0))
      else $error("result while skipping");

   a_row_end_clears: assert property (@(posedge clock) disable iff (reset)
      (step && result.row_end) |=> (total_ff == '0 && !started_ff))
      else $error("row end did not clear state");

endmodule

>>> design/csv_field_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer
// Splits one CSV line per row into fields, one byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one line byte per request (0 ends a buffer without newline).
//   rsp_* carries one result per request: content bytes of the current field
//   (0..2), field close, and on rsp_tlast the row status and error field.
//   Each request passes through the input register, then the result register.
//   Throughput: one request per cycle while the receiver takes results; the
//   single step logic between the two registers handles each byte in full.
//   A request is still taken while a result waits on a stalled receiver, as
//   long as the input register is free; with both registers full, req_tready
//   drops until rsp_tready returns. Results never drop or repeat.
//   Reset clears the parser to the start of a row with no fields and empties
//   both registers.
//   MAX_FIELDS sets the per-row field limit (capped at 255).
// ----------------------------------------------------------------------------
module csv_field_tokenizer #(
   parameter int unsigned MAX_FIELDS = cft_pkg::MAX_FIELDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [1:0] content_count, [9:2] content_first,
                                    // [17:10] content_second, [18] field_end,
                                    // [20:19] row_status, [29:21] error_field,
                                    // [37:30] fields_so_far, [39:38] zero
   output logic        rsp_tlast    // row_end
);

   logic                in_v_ff, in_v_in;
   logic [7:0]          in_byte_ff;
   logic                out_v_ff, out_v_in;
   cft_pkg::result_type out_ff;
   cft_pkg::result_type step_res;
   logic                advance;
   logic                step;

   assign advance    = !out_v_ff || rsp_tready;
   assign req_tready = !in_v_ff || advance;
   assign step       = in_v_ff && advance;

   cft_parse_core #(
      .MAX_FIELDS (MAX_FIELDS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .result    (step_res)
   );

   always_comb begin
      in_v_in = in_v_ff;
      if (req_tvalid && req_tready) begin
         in_v_in = 1'b1;
      end else if (advance) begin
         in_v_in = 1'b0;
      end
      out_v_in = advance ? in_v_ff : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (step) begin
         out_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = out_ff.row_end;
   assign rsp_tdata  = {2'b00, out_ff.fields_so_far, out_ff.error_field,
                        out_ff.row_status, out_ff.field_end,
                        out_ff.content_second, out_ff.content_first,
                        out_ff.content_count};

   a_step_fills_out: assert property (@(posedge clock) disable iff (reset)
      step |=> out_v_ff)
      else $error("stepped request lost");

   a_status_needs_end: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_ff.row_status != cft_pkg::STATUS_OK) |-> out_ff.row_end)
      else $error("status without row end");

   a_ok_no_error: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_ff.row_status == cft_pkg::STATUS_OK) |->
      (out_ff.error_field == '0))
      else $error("error field on ok row");

   a_content_zeroed: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_ff.content_count != 2'd2) |-> (out_ff.content_second == '0))
      else $error("stale second content byte");

endmodule
